>>> design/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// shared types and constants of the pushbuffer command parser
// ----------------------------------------------------------------------------
package pcp_pkg;

    // error codes, sticky in the execute stage
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_PROT = 3'd1;
    localparam logic [2:0] ERR_CALL = 3'd2;
    localparam logic [2:0] ERR_RET  = 3'd3;
    localparam logic [2:0] ERR_RSVD = 3'd4;

    // header decode masks
    localparam logic [31:0] OLD_JUMP_MASK  = 32'he000_0003;
    localparam logic [31:0] OLD_JUMP_CODE  = 32'h2000_0000;
    localparam logic [31:0] OLD_JUMP_ADDR  = 32'h1fff_ffff;
    localparam logic [31:0] ADDR_MASK      = 32'hffff_fffc;
    localparam logic [31:0] RETURN_WORD    = 32'h0002_0000;
    localparam logic [31:0] METHOD_MASK    = 32'he003_0003;
    localparam logic [31:0] METHOD_NONINC  = 32'h4000_0000;
    localparam logic [1:0]  TAG_JUMP       = 2'd1;
    localparam logic [1:0]  TAG_CALL       = 2'd2;

    // depth of the queue between decode and execute
    localparam int QUEUE_DEPTH = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [2:0] {
        KIND_OLD_JUMP,
        KIND_JUMP,
        KIND_CALL,
        KIND_RETURN,
        KIND_METHOD,
        KIND_RESERVED
    } t_kind;

    // classified item passed from decode to execute
    typedef struct packed {
        logic [31:0] word;
        logic        cache_full;
        t_kind       kind;
        logic        non_inc;
    } t_cmd;

    // result item, lowest field in the lowest bits
    typedef struct packed {
        logic [10:0] data_count;
        logic        interrupt;
        logic [2:0]  error_code;
        logic [6:0]  cache_slot;
        logic [31:0] data;
        logic        non_increasing;
        logic [2:0]  subchannel;
        logic [10:0] method_index;
        logic        emit;
        logic [31:0] next_get;
        logic        accepted;
    } t_result;

endpackage

>>> design/pcp_front.sv
// ----------------------------------------------------------------------------
// pcp_front
// input register and header classification of pushbuffer words
// ----------------------------------------------------------------------------
module pcp_front import pcp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // word[31:0], cache_full[32]
    output logic                  o_valid,
    output t_cmd                  o_cmd,
    input  logic                  i_ready
);

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic [31:0] w;

    assign w = s_axis_tdata[31:0];

    always_comb begin
        n_cmd            = '0;
        n_cmd.word       = w;
        n_cmd.cache_full = s_axis_tdata[32];
        n_cmd.non_inc    = ((w & METHOD_MASK) == METHOD_NONINC);
        if ((w & OLD_JUMP_MASK) == OLD_JUMP_CODE) begin
            n_cmd.kind = KIND_OLD_JUMP;
        end else if (w[1:0] == TAG_JUMP) begin
            n_cmd.kind = KIND_JUMP;
        end else if (w[1:0] == TAG_CALL) begin
            n_cmd.kind = KIND_CALL;
        end else if (w == RETURN_WORD) begin
            n_cmd.kind = KIND_RETURN;
        end else if ((w & METHOD_MASK) == '0 || (w & METHOD_MASK) == METHOD_NONINC) begin
            n_cmd.kind = KIND_METHOD;
        end else begin
            n_cmd.kind = KIND_RESERVED;
        end
    end

    assign s_axis_tready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

>>> design/pcp_queue.sv
// ----------------------------------------------------------------------------
// pcp_queue
// short fifo between decode and execute
// ----------------------------------------------------------------------------
module pcp_queue import pcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_en;
    logic             pop_en;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push_en = i_push && o_ready;
    assign pop_en  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + 1'b1;
            end else if (pop_en && !push_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> design/pcp_back.sv
// ----------------------------------------------------------------------------
// pcp_back
// executes classified words against parser state, registers the result
// ----------------------------------------------------------------------------
module pcp_back import pcp_pkg::*; #(
    parameter int CACHE_ENTRIES = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [31:0]            i_dma_limit,
    input  logic                   i_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int SLOT_W = $clog2(CACHE_ENTRIES);

    logic [31:0]       r_get,       n_get;
    logic              r_sub,       n_sub;
    logic [31:0]       r_ret,       n_ret;
    logic [10:0]       r_method,    n_method;
    logic [2:0]        r_subch,     n_subch;
    logic              r_type,      n_type;
    logic [10:0]       r_remaining, n_remaining;
    logic [10:0]       r_done,      n_done;
    logic [2:0]        r_err,       n_err;
    logic [SLOT_W-1:0] r_slot,      n_slot;
    logic              r_out_valid;
    t_result           r_res,       n_res;
    logic [31:0]       g;
    logic              ok;
    logic [SLOT_W+6:0] slot_ext;

    assign o_pop    = i_valid && (!r_out_valid || m_axis_tready);
    assign slot_ext = {7'd0, r_slot};

    always_comb begin
        n_get       = r_get;
        n_sub       = r_sub;
        n_ret       = r_ret;
        n_method    = r_method;
        n_subch     = r_subch;
        n_type      = r_type;
        n_remaining = r_remaining;
        n_done      = r_done;
        n_err       = r_err;
        n_slot      = r_slot;
        n_res       = '0;
        g           = r_get + 32'd4;
        ok          = 1'b1;
        if (r_err == ERR_NONE) begin
            if (r_get >= i_dma_limit) begin
                n_err           = ERR_PROT;
                n_res.interrupt = 1'b1;
            end else if (r_remaining != '0) begin
                // data word: one cache entry unless the cache is full
                if (!i_cmd.cache_full) begin
                    n_res.emit           = 1'b1;
                    n_res.method_index   = r_method;
                    n_res.subchannel     = r_subch;
                    n_res.non_increasing = r_type;
                    n_res.data           = i_cmd.word;
                    n_res.cache_slot     = slot_ext[6:0];
                    n_slot = (r_slot == SLOT_W'(CACHE_ENTRIES - 1)) ? '0 : r_slot + 1'b1;
                    if (!r_type) begin
                        n_method = r_method + 1'b1;
                    end
                    n_remaining    = r_remaining - 1'b1;
                    n_done         = r_done + 1'b1;
                    n_res.accepted = 1'b1;
                    n_get          = g;
                end
            end else begin
                unique case (i_cmd.kind)
                    KIND_OLD_JUMP: g = i_cmd.word & OLD_JUMP_ADDR;
                    KIND_JUMP:     g = i_cmd.word & ADDR_MASK;
                    KIND_CALL: begin
                        if (r_sub) begin
                            n_err = ERR_CALL;
                            ok    = 1'b0;
                        end else begin
                            n_ret = g;
                            n_sub = 1'b1;
                            g     = i_cmd.word & ADDR_MASK;
                        end
                    end
                    KIND_RETURN: begin
                        if (!r_sub) begin
                            n_err = ERR_RET;
                            ok    = 1'b0;
                        end else begin
                            g     = r_ret;
                            n_sub = 1'b0;
                        end
                    end
                    KIND_METHOD: begin
                        n_method    = i_cmd.word[12:2];
                        n_subch     = i_cmd.word[15:13];
                        n_remaining = i_cmd.word[28:18];
                        n_type      = i_cmd.non_inc;
                        n_done      = '0;
                    end
                    default: begin
                        n_err = ERR_RSVD;
                        ok    = 1'b0;
                    end
                endcase
                if (ok) begin
                    n_res.accepted = 1'b1;
                    n_get          = g;
                end else begin
                    n_res.interrupt = 1'b1;
                end
            end
        end
        n_res.next_get   = n_get;
        n_res.error_code = n_err;
        n_res.data_count = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_get       <= '0;
            r_sub       <= 1'b0;
            r_ret       <= '0;
            r_method    <= '0;
            r_subch     <= '0;
            r_type      <= 1'b0;
            r_remaining <= '0;
            r_done      <= '0;
            r_err       <= ERR_NONE;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_get       <= n_get;
                r_sub       <= n_sub;
                r_ret       <= n_ret;
                r_method    <= n_method;
                r_subch     <= n_subch;
                r_type      <= n_type;
                r_remaining <= n_remaining;
                r_done      <= n_done;
                r_err       <= n_err;
                r_slot      <= n_slot;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_res};

    // an emitted entry always consumes its word
    a_emit_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_res.emit || r_res.accepted))
        else $error("entry emitted without consuming the word");

    // an interrupt always comes with a held error
    a_irq_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.interrupt |-> (r_res.error_code != ERR_NONE))
        else $error("interrupt without error");

    // errors are sticky
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |=> (r_err == $past(r_err)))
        else $error("sticky error changed");

    // get pointer only moves on an accepted word
    a_get_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !n_res.accepted |=> $stable(r_get))
        else $error("get pointer moved on a rejected word");

endmodule

>>> design/pushbuffer_command_parser_top.sv
// ----------------------------------------------------------------------------
// pushbuffer_command_parser_top
// pushbuffer command parser: decodes fetched words into command cache entries
// ----------------------------------------------------------------------------
// Takes one pushbuffer word per item on the s_axis side and returns exactly one
// result item per word on the m_axis side. Items flow at one per clock cycle,
// back to back, while the output is not stalled. A result passes the input
// register, the queue and the execute register before it shows on m_axis. The
// decode front end classifies each word as it arrives; a short queue lets it
// keep taking words while the execute stage waits on a stalled output. The
// execute stage holds the get pointer, subroutine return pointer, current
// method and the sticky error, and settles one word per cycle while the output
// is not stalled; that single state update loop sets the rate. The dma_limit
// register is at byte address 0 of the APB port and must only be written while
// no item is in flight.
// ----------------------------------------------------------------------------
module pushbuffer_command_parser_top import pcp_pkg::*; #(
    parameter int CACHE_ENTRIES = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // word[31:0], cache_full[32]
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // accepted[0], next_get[32:1], emit[33], method_index[44:34],
    // subchannel[47:45], non_increasing[48], data[80:49], cache_slot[87:81],
    // error_code[90:88], interrupt[91], data_count[102:92]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [31:0] r_dma_limit;
    logic        f_valid;
    t_cmd        f_cmd;
    logic        q_ready;
    logic        q_valid;
    t_cmd        q_cmd;
    logic        b_pop;
    logic        cfg_wr;

    // config register, single access-cycle write
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : r_dma_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_limit <= '0;
        end else if (cfg_wr) begin
            r_dma_limit <= pwdata;
        end
    end

    // decode front end
    pcp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_valid       (f_valid),
        .o_cmd         (f_cmd),
        .i_ready       (q_ready)
    );

    // decouples decode from execute
    pcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (b_pop)
    );

    // execute stage with result register
    pcp_back #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dma_limit   (r_dma_limit),
        .i_valid       (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (b_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> tb/pcp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcp_result_checker
// predicts the result of every accepted pushbuffer word and checks the
// result items of the parser against those predictions, in order
// ----------------------------------------------------------------------------
module pcp_result_checker import pcp_pkg::*; #(
    parameter int         CACHE_ENTRIES = 128,
    parameter logic [2:0] LIMIT_ADDR    = 3'd0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [2:0]             i_paddr,
    input  logic [31:0]            i_pwdata,
    input  logic [31:0]            i_prdata,
    input  logic                   i_pready,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    // parser state as the predictor sees it
    logic [31:0] dma_limit;
    logic [31:0] get_ptr;
    logic [31:0] ret_ptr;
    logic        in_sub;
    logic [10:0] method_q;
    logic [2:0]  subch_q;
    logic        noninc_q;
    logic [10:0] words_left;
    logic [10:0] words_done;
    logic [2:0]  error_q;
    int unsigned slot_q;

    t_result predicted_results[$];
    int      mismatches = 0;
    int      results_seen = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: result %0d: %s is 0x%0h, want 0x%0h",
                 $realtime, results_seen, what, got, want);
    endtask

    // one pushbuffer word against the kept state
    function automatic t_result decode_word(input logic [31:0] w, input logic full);
        t_result     r;
        logic [31:0] next_ptr;
        logic        ok;
        r = '0;
        if (error_q == ERR_NONE) begin
            if (get_ptr >= dma_limit) begin
                error_q     = ERR_PROT;
                r.interrupt = 1'b1;
            end else if (words_left != 0) begin
                // data word, stalls while the cache is full
                if (!full) begin
                    r.emit           = 1'b1;
                    r.method_index   = method_q;
                    r.subchannel     = subch_q;
                    r.non_increasing = noninc_q;
                    r.data           = w;
                    r.cache_slot     = 7'(slot_q);
                    slot_q           = (slot_q + 1) % CACHE_ENTRIES;
                    if (!noninc_q) begin
                        method_q = method_q + 11'd1;
                    end
                    words_left = words_left - 11'd1;
                    words_done = words_done + 11'd1;
                    r.accepted = 1'b1;
                    get_ptr    = get_ptr + 32'd4;
                end
            end else begin
                next_ptr = get_ptr + 32'd4;
                ok       = 1'b1;
                if ((w & OLD_JUMP_MASK) == OLD_JUMP_CODE) begin
                    next_ptr = w & OLD_JUMP_ADDR;
                end else if (w[1:0] == TAG_JUMP) begin
                    next_ptr = w & ADDR_MASK;
                end else if (w[1:0] == TAG_CALL) begin
                    if (in_sub) begin
                        error_q = ERR_CALL;
                        ok      = 1'b0;
                    end else begin
                        ret_ptr  = next_ptr;
                        in_sub   = 1'b1;
                        next_ptr = w & ADDR_MASK;
                    end
                end else if (w == RETURN_WORD) begin
                    if (!in_sub) begin
                        error_q = ERR_RET;
                        ok      = 1'b0;
                    end else begin
                        next_ptr = ret_ptr;
                        in_sub   = 1'b0;
                    end
                end else if ((w & METHOD_MASK) == '0 || (w & METHOD_MASK) == METHOD_NONINC) begin
                    method_q   = w[12:2];
                    subch_q    = w[15:13];
                    words_left = w[28:18];
                    noninc_q   = ((w & METHOD_MASK) == METHOD_NONINC);
                    words_done = '0;
                end else begin
                    error_q = ERR_RSVD;
                    ok      = 1'b0;
                end
                if (ok) begin
                    r.accepted = 1'b1;
                    get_ptr    = next_ptr;
                end else begin
                    r.interrupt = 1'b1;
                end
            end
        end
        r.next_get   = get_ptr;
        r.error_code = error_q;
        r.data_count = words_done;
        return r;
    endfunction

    task automatic compare_result(input t_result got, input t_result want);
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.next_get !== want.next_get)
            report_mismatch("next_get", got.next_get, want.next_get);
        if (got.emit !== want.emit)
            report_mismatch("emit", 32'(got.emit), 32'(want.emit));
        if (got.method_index !== want.method_index)
            report_mismatch("method_index", 32'(got.method_index),
                            32'(want.method_index));
        if (got.subchannel !== want.subchannel)
            report_mismatch("subchannel", 32'(got.subchannel), 32'(want.subchannel));
        if (got.non_increasing !== want.non_increasing)
            report_mismatch("non_increasing", 32'(got.non_increasing),
                            32'(want.non_increasing));
        if (got.data !== want.data)
            report_mismatch("data", got.data, want.data);
        if (got.cache_slot !== want.cache_slot)
            report_mismatch("cache_slot", 32'(got.cache_slot), 32'(want.cache_slot));
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
        if (got.interrupt !== want.interrupt)
            report_mismatch("interrupt", 32'(got.interrupt), 32'(want.interrupt));
        if (got.data_count !== want.data_count)
            report_mismatch("data_count", 32'(got.data_count), 32'(want.data_count));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            dma_limit  = '0;
            get_ptr    = '0;
            ret_ptr    = '0;
            in_sub     = 1'b0;
            method_q   = '0;
            subch_q    = '0;
            noninc_q   = 1'b0;
            words_left = '0;
            words_done = '0;
            error_q    = ERR_NONE;
            slot_q     = 0;
            predicted_results.delete();
            o_outstanding <= 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == LIMIT_ADDR) begin
                if (i_pwrite) begin
                    dma_limit = i_pwdata;
                end else if (i_prdata !== dma_limit) begin
                    report_mismatch("prdata", i_prdata, dma_limit);
                end
            end
            if (i_out_tvalid && i_out_tready) begin
                got = i_out_tdata[$bits(t_result)-1:0];
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected item, next_get", got.next_get, '0);
                end else begin
                    compare_result(got, predicted_results.pop_front());
                end
                results_seen++;
            end
            if (i_in_tvalid && i_in_tready) begin
                predicted_results.push_back(decode_word(i_in_tdata[31:0], i_in_tdata[32]));
            end
            o_outstanding <= predicted_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the pushbuffer command parser
// ----------------------------------------------------------------------------
// A short directed run hits method address wrap, a cache stall, a zero count
// header, all jump kinds, a call and return and the get pointer wrap. Then four
// random phases of well-formed command streams run under different dma_limit
// settings, one of them with a long method and no idling. Since
// errors are sticky until reset, the run ends with one error of a randomly
// picked kind followed by a few words that must all be refused.
// ----------------------------------------------------------------------------
module tb_top;
    import pcp_pkg::*;

    localparam int         CACHE_ENTRIES  = 128;
    localparam logic [2:0] DMA_LIMIT_ADDR = 3'd0;
    // targets stay this far below the limit so a phase never runs into it
    localparam logic [31:0] LIMIT_MARGIN  = 32'h0000_4000;

    // how the run is brought to its sticky error
    typedef enum int {
        END_PROT,
        END_CALL,
        END_RET,
        END_RSVD
    } t_ending;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // word[31:0], cache_full[32]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // accepted, next_get, emit, method_index, subchannel, non_increasing,
    // data, cache_slot, error_code, interrupt, data_count
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [2:0]             paddr         = '0;
    logic [31:0]            pwdata        = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int mismatches;
    int outstanding;

    // set during the stretch where neither side idles
    bit no_idle = 1'b0;

    // where the stream stands, kept so that no error comes before the end
    logic [31:0] cur_get    = '0;
    logic [31:0] cur_ret    = '0;
    logic [31:0] cur_limit  = '0;
    logic        in_call    = 1'b0;
    logic [10:0] words_owed = '0;

    t_ending ending;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    pushbuffer_command_parser_top #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pcp_result_checker #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .LIMIT_ADDR    (DMA_LIMIT_ADDR)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // result side backpressure, about one cycle in ten
    always @(posedge i_clk) begin
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one item on the input side; tvalid stays up after the handshake so
    // back to back items need no second assignment in the same step
    task automatic push_word(input logic [31:0] w, input logic full);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 4) begin
            gap = $urandom_range(1, 4);
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 33){1'b0}}, full, w};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_data(input logic [31:0] w, input logic full);
        push_word(w, full);
        if (!full && words_owed != 0) begin
            words_owed = words_owed - 11'd1;
            cur_get    = cur_get + 32'd4;
        end
    endtask

    task automatic send_method(input logic noninc, input logic [10:0] meth,
                               input logic [2:0] subch, input logic [10:0] count,
                               input logic full);
        push_word({noninc ? 3'b010 : 3'b000, count, 2'b00, subch, meth, 2'b00}, full);
        words_owed = count;
        cur_get    = cur_get + 32'd4;
    endtask

    task automatic send_jump(input logic [31:0] target, input logic full);
        push_word((target & ADDR_MASK) | {30'd0, TAG_JUMP}, full);
        cur_get = target & ADDR_MASK;
    endtask

    task automatic send_old_jump(input logic [31:0] target, input logic full);
        push_word(OLD_JUMP_CODE | (target & OLD_JUMP_ADDR & ADDR_MASK), full);
        cur_get = target & OLD_JUMP_ADDR & ADDR_MASK;
    endtask

    task automatic send_call(input logic [31:0] target, input logic full);
        push_word((target & ADDR_MASK) | {30'd0, TAG_CALL}, full);
        cur_ret = cur_get + 32'd4;
        in_call = 1'b1;
        cur_get = target & ADDR_MASK;
    endtask

    task automatic send_return(input logic full);
        push_word(RETURN_WORD, full);
        cur_get = cur_ret;
        in_call = 1'b0;
    endtask

    // data words until the open method is done, with random cache stalls
    task automatic finish_method();
        while (words_owed != 0) begin
            send_data($urandom, $urandom_range(0, 99) < 15);
        end
    endtask

    // jump targets keep a margin below the limit
    function automatic logic [31:0] pick_target();
        return $urandom_range(0, cur_limit - LIMIT_MARGIN) & ADDR_MASK;
    endfunction

    // lowest limit that keeps the get and return pointers clear of it
    function automatic logic [31:0] limit_floor(input longint unsigned extra);
        longint unsigned lowest;
        lowest = 64'(cur_get);
        if (in_call && cur_ret > cur_get) begin
            lowest = 64'(cur_ret);
        end
        lowest = lowest + LIMIT_MARGIN + extra;
        if (lowest > 64'hffff_ffff) begin
            lowest = 64'hffff_ffff;
        end
        return lowest[31:0];
    endfunction

    task automatic random_item();
        int   pick;
        logic full;
        pick = $urandom_range(0, 99);
        full = ($urandom_range(0, 99) < 15);
        if (words_owed != 0) begin
            send_data($urandom, full);
        end else if (pick < 55) begin
            // mostly short methods, now and then a zero count header
            send_method(1'($urandom_range(0, 1)), 11'($urandom), 3'($urandom),
                        ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 12)),
                        full);
        end else if (pick < 67) begin
            send_jump(pick_target(), full);
        end else if (pick < 77) begin
            send_old_jump(pick_target(), full);
        end else if (!in_call) begin
            send_call(pick_target(), full);
        end else begin
            send_return(full);
        end
    endtask

    // setup cycle, access cycle, then a quiet cycle on the bus
    task automatic apb_access(input logic is_write, input logic [2:0] addr,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // limit changes only with nothing in flight; read back for the checker
    task automatic set_limit(input logic [31:0] value);
        wait_drained();
        apb_access(1'b1, DMA_LIMIT_ADDR, value);
        apb_access(1'b0, DMA_LIMIT_ADDR, '0);
        cur_limit = value;
    endtask

    initial begin
        logic [31:0] w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both extremes of the limit, the widest one stays for the directed run
        set_limit(32'd0);
        set_limit(32'hffff_ffff);

        // increasing method whose address wraps past 0x7ff, with one stall
        send_method(1'b0, 11'h7fe, 3'd7, 11'd3, 1'b0);
        send_data(32'hffff_ffff, 1'b0);
        send_data(32'h0000_0000, 1'b1);
        send_data(32'h0000_0000, 1'b0);
        send_data(32'ha5a5_a5a5, 1'b0);
        // non-increasing header is decoded although the cache is full
        send_method(1'b1, 11'h155, 3'd2, 11'd2, 1'b1);
        send_data(32'h1234_5678, 1'b0);
        send_data(32'h8765_4321, 1'b0);
        // zero count header, the next word is a header again
        send_method(1'b0, 11'h2aa, 3'd5, 11'd0, 1'b0);
        send_jump(32'h0000_1000, 1'b1);
        send_old_jump(32'h1fff_fffc, 1'b0);
        // call to the top of the address space, get wraps to zero
        send_call(32'hffff_fffc, 1'b0);
        send_method(1'b0, 11'h000, 3'd0, 11'd1, 1'b0);
        send_data(32'h5a5a_5a5a, 1'b0);
        send_return(1'b0);
        send_jump(32'h0000_0100, 1'b0);

        // random phases, each under its own limit
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1 || phase == 3) begin
                set_limit($urandom_range(limit_floor(0), 32'hffff_ffff));
            end else if (phase == 2) begin
                // tight limit, no idling, one long method
                set_limit(limit_floor(64'($urandom_range(0, 32'hffff))));
                no_idle = 1'b1;
                finish_method();
                send_method(1'($urandom_range(0, 1)), 11'($urandom), 3'($urandom),
                            11'd64, 1'b0);
                finish_method();
            end
            repeat (100) random_item();
            no_idle = 1'b0;
        end

        // close with one sticky error, the header decoder must be free for it
        finish_method();
        ending = t_ending'($urandom_range(0, 3));
        case (ending)
            END_PROT: begin
                // limit at the current get pointer or at zero
                set_limit(($urandom_range(0, 1) != 0) ? 32'd0 : cur_get);
                push_word($urandom, 1'($urandom_range(0, 1)));
            end
            END_CALL: begin
                if (!in_call) begin
                    send_call(pick_target(), 1'b0);
                end
                push_word(pick_target() | {30'd0, TAG_CALL}, 1'($urandom_range(0, 1)));
            end
            END_RET: begin
                if (in_call) begin
                    send_return(1'b0);
                end
                push_word(RETURN_WORD, 1'($urandom_range(0, 1)));
            end
            default: begin
                // reserved: low bits 11, or a method-like word with a bad top code
                w = $urandom;
                if ($urandom_range(0, 1) != 0) begin
                    w[1:0] = 2'b11;
                end else begin
                    w[1:0]   = 2'b00;
                    w[31:29] = 3'($urandom_range(3, 7));
                end
                push_word(w, 1'($urandom_range(0, 1)));
            end
        endcase
        // every word after the error is refused
        repeat (6) push_word($urandom, 1'($urandom_range(0, 1)));

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // run time guard
    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
